// ----- hdl/bpc_pkg.sv -----
// Package with shared types and constants for the button press classifier.
`default_nettype none

package bpc_pkg;

    localparam int unsigned TimeWidth   = 32;
    localparam int unsigned CfgWidth    = 16;
    localparam int unsigned CfgIdxWidth = 8;
    localparam int unsigned EventWidth  = 3;

    typedef logic [TimeWidth-1:0]   time_ticks_t;
    typedef logic [CfgWidth-1:0]    cfg_word_t;
    typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

    typedef enum logic [EventWidth-1:0] {
        EV_NONE      = 3'd0,
        EV_SINGLE    = 3'd1,
        EV_LONG      = 3'd2,
        EV_VERY_LONG = 3'd3,
        EV_DOUBLE    = 3'd4
    } press_event_t;

    localparam cfg_idx_t CFG_DEBOUNCE   = 8'd0;
    localparam cfg_idx_t CFG_DOUBLE_GAP = 8'd1;
    localparam cfg_idx_t CFG_SHORT_HOLD = 8'd2;
    localparam cfg_idx_t CFG_LONG_HOLD  = 8'd3;

    localparam cfg_word_t DEBOUNCE_RESET   = 16'd20;
    localparam cfg_word_t DOUBLE_GAP_RESET = 16'd250;
    localparam cfg_word_t SHORT_HOLD_RESET = 16'd300;
    localparam cfg_word_t LONG_HOLD_RESET  = 16'd5000;

    typedef struct packed {
        cfg_word_t debounce_ticks;
        cfg_word_t double_gap_ticks;
        cfg_word_t short_hold_ticks;
        cfg_word_t long_hold_ticks;
    } bpc_cfg_t;

endpackage

`default_nettype wire

// ----- hdl/bpc_classify.sv -----
// Debounce and press classification state, updated once per accepted sample.
`default_nettype none

module bpc_classify (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bpc_pkg::bpc_cfg_t     cfg,
    input  wire logic                  sample_en,
    input  wire logic                  raw_level,
    input  wire bpc_pkg::time_ticks_t  now_ticks,
    output bpc_pkg::press_event_t      event_code
);

    logic                 stable_level_reg;
    logic                 stable_level_next;
    bpc_pkg::time_ticks_t last_change_time_reg;
    bpc_pkg::time_ticks_t last_change_time_next;
    bpc_pkg::time_ticks_t press_time_reg;
    bpc_pkg::time_ticks_t press_time_next;
    bpc_pkg::time_ticks_t release_time_reg;
    bpc_pkg::time_ticks_t release_time_next;
    logic                 awaiting_second_reg;
    logic                 awaiting_second_next;

    bpc_pkg::time_ticks_t since_change;
    bpc_pkg::time_ticks_t since_press;
    bpc_pkg::time_ticks_t since_release;
    bpc_pkg::time_ticks_t stored_hold;
    bpc_pkg::time_ticks_t hold_len;
    logic                 level_change;
    logic                 press_edge;
    logic                 release_edge;
    logic                 awaiting_mid;

    assign since_change  = now_ticks - last_change_time_reg;
    assign since_press   = now_ticks - press_time_reg;
    assign since_release = now_ticks - release_time_reg;
    assign stored_hold   = release_time_reg - press_time_reg;

    assign level_change = (since_change > {16'd0, cfg.debounce_ticks})
                          && (raw_level != stable_level_reg);
    assign press_edge   = level_change && raw_level;
    assign release_edge = level_change && !raw_level;
    assign hold_len     = release_edge ? since_press : stored_hold;

    always_comb
    begin
        stable_level_next     = level_change ? raw_level : stable_level_reg;
        last_change_time_next = level_change ? now_ticks : last_change_time_reg;
        press_time_next       = press_edge ? now_ticks : press_time_reg;
        release_time_next     = release_edge ? now_ticks : release_time_reg;
        event_code            = bpc_pkg::EV_NONE;
        awaiting_mid          = awaiting_second_reg;

        if (release_edge)
        begin
            if (awaiting_second_reg)
            begin
                event_code   = bpc_pkg::EV_DOUBLE;
                awaiting_mid = 1'b0;
            end
            else
            begin
                awaiting_mid = 1'b1;
            end
        end

        awaiting_second_next = awaiting_mid;

        // The gap and very-long checks are skipped on the sample that starts their timers.
        priority if (!stable_level_next && awaiting_mid && !release_edge
                     && (since_release > {16'd0, cfg.double_gap_ticks}))
        begin
            awaiting_second_next = 1'b0;
            event_code           = bpc_pkg::EV_SINGLE;
        end
        else if (!stable_level_next && awaiting_mid
                 && (hold_len >= {16'd0, cfg.short_hold_ticks})
                 && (hold_len <= {16'd0, cfg.long_hold_ticks}))
        begin
            awaiting_second_next = 1'b0;
            event_code           = bpc_pkg::EV_LONG;
        end
        else if (stable_level_next && !press_edge
                 && (since_press > {16'd0, cfg.long_hold_ticks}))
        begin
            awaiting_second_next = 1'b0;
            event_code           = bpc_pkg::EV_VERY_LONG;
        end
        else
        begin
            awaiting_second_next = awaiting_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_level_reg     <= 1'b0;
            last_change_time_reg <= '0;
            press_time_reg       <= '0;
            release_time_reg     <= '0;
            awaiting_second_reg  <= 1'b0;
        end
        else if (sample_en)
        begin
            stable_level_reg     <= stable_level_next;
            last_change_time_reg <= last_change_time_next;
            press_time_reg       <= press_time_next;
            release_time_reg     <= release_time_next;
            awaiting_second_reg  <= awaiting_second_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/button_press_classifier_core.sv -----
// Top level of the debounced button press classifier with config and output buffering.
//
// Each input request carries one sample of the raw button level and the value of a
// free-running 32-bit tick counter. The level is debounced and presses are classified
// as single, double, long or very long; every sample yields exactly one output request
// with press_event (0 none, 1 single, 2 long, 3 very long, 4 double).
// A result is registered at the edge that accepts its sample, into the main output
// register, or the skid register if the main one holds a result not taken; throughput is
// one sample per cycle while in_ready is high, set by the single classifier state stage.
// The output side has a main register and a skid register, so a sample is still
// accepted while one finished result waits; in_ready drops only when both hold data.
// Configuration writes are always accepted (cfg_ready is high); indexes 0 to 3 select
// debounce, double gap, short hold and long hold, other indexes are ignored, and the data
// word is 16 bits wide. Writes are meant to happen while the block is idle.
// Reset loads the default thresholds, clears all state and empties the output buffer.
`default_nettype none

module button_press_classifier_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire bpc_pkg::cfg_idx_t          cfg_index,
    input  wire bpc_pkg::cfg_word_t         cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       raw_level,
    input  wire bpc_pkg::time_ticks_t       now_ticks,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [bpc_pkg::EventWidth-1:0]  press_event
);

    bpc_pkg::bpc_cfg_t     cfg_reg;
    bpc_pkg::press_event_t event_code;
    bpc_pkg::press_event_t out_event_reg;
    bpc_pkg::press_event_t skid_event_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic                  in_fire;
    logic                  out_take;

    assign cfg_ready   = 1'b1;
    assign in_ready    = !skid_valid_reg;
    assign in_fire     = in_valid && in_ready;
    assign out_take    = out_valid_reg && out_ready;
    assign out_valid   = out_valid_reg;
    assign press_event = out_event_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= bpc_pkg::DEBOUNCE_RESET;
            cfg_reg.double_gap_ticks <= bpc_pkg::DOUBLE_GAP_RESET;
            cfg_reg.short_hold_ticks <= bpc_pkg::SHORT_HOLD_RESET;
            cfg_reg.long_hold_ticks  <= bpc_pkg::LONG_HOLD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bpc_pkg::CFG_DEBOUNCE:   cfg_reg.debounce_ticks   <= cfg_data;
                bpc_pkg::CFG_DOUBLE_GAP: cfg_reg.double_gap_ticks <= cfg_data;
                bpc_pkg::CFG_SHORT_HOLD: cfg_reg.short_hold_ticks <= cfg_data;
                bpc_pkg::CFG_LONG_HOLD:  cfg_reg.long_hold_ticks  <= cfg_data;
                default:                 cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    bpc_classify u_classify (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .sample_en  (in_fire),
        .raw_level  (raw_level),
        .now_ticks  (now_ticks),
        .event_code (event_code)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_event_reg <= event_code;
            end
            else
            begin
                skid_event_reg <= event_code;
            end
        end
        else if (out_take && skid_valid_reg)
        begin
            out_event_reg <= skid_event_reg;
        end
    end

endmodule

`default_nettype wire
